// ===== hdl/ntg_pkg.sv =====
// ----------------------------------------------------------------------------
// ntg_pkg
// Shared widths and constants for the noise texture generator.
// ----------------------------------------------------------------------------
`default_nettype none

package ntg_pkg;

   localparam int unsigned AddrWidth  = 16;
   localparam int unsigned TexelWidth = 8;
   localparam int unsigned StepWidth  = AddrWidth + 1;

   localparam logic [AddrWidth-1:0]  MIRROR_MASK = 16'hFF00;
   localparam logic [AddrWidth-1:0]  LOOKAHEAD   = 16'd128;
   localparam logic [TexelWidth-1:0] SEED_RESET  = 8'h03;

   // Request kind codes
   localparam logic KIND_GEN  = 1'b0;
   localparam logic KIND_READ = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/noise_texture_generator.sv =====
// ----------------------------------------------------------------------------
// noise_texture_generator
// Fills a 64K-byte texel store with smoothed noise, one step per generate
// request, and returns stored texels on read requests.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_kind, req_read_address
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_data, rsp_address, rsp_done_res
//  csr     | in        | csr_valid/csr_ready  | csr_seed_byte
//
//  After reset the store is cleared one byte a cycle, with req_ready low
//  until the last byte is written (csr writes are taken throughout).
//  A generate request runs ST_ROT, where the one-bit-per-cycle rotate unit
//  turns a mod 32 positions, then ST_ADD1, ST_ADD2, ST_WR_MIR and ST_RESP;
//  a read or a generate after completion goes straight to ST_RESP.
//  One request at a time; a new one is accepted while a result still waits.
//  A stalled result holds the block in its response state until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module noise_texture_generator (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_kind,
   input  wire logic [ntg_pkg::AddrWidth-1:0]      req_read_address,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [ntg_pkg::TexelWidth-1:0]          rsp_data,
   output logic [ntg_pkg::AddrWidth-1:0]           rsp_address,
   output logic                                    rsp_done_res,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [ntg_pkg::TexelWidth-1:0]     csr_seed_byte
);
   import ntg_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_ROT, ST_ADD1, ST_ADD2, ST_WR_MIR, ST_RESP
   } state_type;

   typedef enum logic [1:0] {OP_GEN, OP_READ, OP_NOP} op_type;

   state_type                state_ff;
   op_type                   op_ff;
   logic [AddrWidth-1:0]     clr_cnt_ff;
   logic [StepWidth-1:0]     step_cnt_ff;
   logic [TexelWidth-1:0]    seed_ff;
   logic [TexelWidth-1:0]    rot_ff;
   logic                     carry_ff;
   logic [TexelWidth-1:0]    acc_ff;
   logic [4:0]               rot_cnt_ff;
   logic [AddrWidth-1:0]     addr_ff;
   logic                     rsp_valid_ff;
   logic [TexelWidth-1:0]    rsp_data_ff;
   logic [AddrWidth-1:0]     rsp_address_ff;
   logic                     rsp_done_ff;

   logic [TexelWidth-1:0]    texel_mem_ff [2**AddrWidth];
   logic [TexelWidth-1:0]    mem_rd_ff;

   logic                     req_accept;
   logic                     done;
   logic [AddrWidth-1:0]     step_addr_in;
   logic                     mem_rd_en;
   logic [AddrWidth-1:0]     mem_rd_addr;
   logic                     mem_wr_en;
   logic [AddrWidth-1:0]     mem_wr_addr;
   logic [TexelWidth-1:0]    mem_wr_data;
   logic [TexelWidth-1:0]    shifted;
   logic [TexelWidth-1:0]    add_b;
   logic                     add_cin;
   logic [TexelWidth:0]      add_sum;
   logic                     rsp_free;

   assign req_ready  = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_accept = req_valid && req_ready;
   assign done       = step_cnt_ff[StepWidth-1];
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   // a = 0 for step 0, else 65536 - step
   assign step_addr_in = AddrWidth'(({AddrWidth{1'b0}}) - step_cnt_ff[AddrWidth-1:0]);

   // Shared 8-bit adder: rotate term in ADD1, lookahead texel in ADD2
   assign shifted = {{3{rot_ff[7]}}, rot_ff[7:3]};
   assign add_b   = (state_ff == ST_ADD1) ? shifted : mem_rd_ff;
   assign add_cin = (state_ff == ST_ADD1) ? rot_ff[2] : carry_ff;
   assign add_sum = {1'b0, acc_ff} + {1'b0, add_b} + {{TexelWidth{1'b0}}, add_cin};

   assign mem_rd_en   = req_accept;
   assign mem_rd_addr = (req_kind == KIND_READ) ? req_read_address
                                                : AddrWidth'(step_addr_in + LOOKAHEAD);

   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = addr_ff;
      mem_wr_data = {1'b0, add_sum[TexelWidth-1:1]};
      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_cnt_ff;
            mem_wr_data = '0;
         end
         ST_ADD2: begin
            mem_wr_en = 1'b1;
         end
         ST_WR_MIR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = addr_ff ^ MIRROR_MASK;
            mem_wr_data = acc_ff;
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         texel_mem_ff[mem_wr_addr] <= mem_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         mem_rd_ff <= texel_mem_ff[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         op_ff        <= OP_GEN;
         clr_cnt_ff   <= '0;
         step_cnt_ff  <= '0;
         seed_ff      <= SEED_RESET;
         rot_ff       <= SEED_RESET;
         carry_ff     <= 1'b0;
         acc_ff       <= '0;
         rot_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            seed_ff <= csr_seed_byte;
         end
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_RESP)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (&clr_cnt_ff) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_accept) begin
                  if (req_kind == KIND_READ) begin
                     op_ff    <= OP_READ;
                     addr_ff  <= req_read_address;
                     state_ff <= ST_RESP;
                  end else if (done) begin
                     op_ff    <= OP_NOP;
                     addr_ff  <= '0;
                     state_ff <= ST_RESP;
                  end else begin
                     op_ff      <= OP_GEN;
                     addr_ff    <= step_addr_in;
                     rot_cnt_ff <= step_addr_in[4:0];
                     if (step_cnt_ff == '0) begin
                        rot_ff <= seed_ff;
                     end
                     state_ff <= ST_ROT;
                  end
               end
            end
            ST_ROT: begin
               // 9-bit rotate left through carry, one position a cycle
               if (rot_cnt_ff == '0) begin
                  state_ff <= ST_ADD1;
               end else begin
                  rot_ff     <= {rot_ff[6:0], carry_ff};
                  carry_ff   <= rot_ff[7];
                  rot_cnt_ff <= rot_cnt_ff - 1'b1;
               end
            end
            ST_ADD1: begin
               acc_ff   <= add_sum[TexelWidth-1:0];
               carry_ff <= add_sum[TexelWidth];
               state_ff <= ST_ADD2;
            end
            ST_ADD2: begin
               // carry out of this add is dropped; bit 0 becomes the carry
               acc_ff   <= {1'b0, add_sum[TexelWidth-1:1]};
               carry_ff <= add_sum[0];
               state_ff <= ST_WR_MIR;
            end
            ST_WR_MIR: begin
               step_cnt_ff <= step_cnt_ff + 1'b1;
               state_ff    <= ST_RESP;
            end
            ST_RESP: begin
               if (rsp_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_address_ff <= addr_ff;
                  rsp_done_ff    <= done;
                  case (op_ff)
                     OP_READ: rsp_data_ff <= mem_rd_ff;
                     OP_GEN:  rsp_data_ff <= acc_ff;
                     default: rsp_data_ff <= '0;
                  endcase
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_address  = rsp_address_ff;
   assign rsp_done_res = rsp_done_ff;

`ifndef SYNTHESIS
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      done |=> done)
      else $error("completion flag dropped");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      done |-> (step_cnt_ff[AddrWidth-1:0] == '0))
      else $error("step count beyond store size");

   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("request accepted during clearing pass");

   a_mirror_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR_MIR) |-> (mem_wr_addr == ($past(mem_wr_addr) ^ MIRROR_MASK)))
      else $error("mirror write address mismatch");

   a_rsp_only_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RESP))
      else $error("result raised outside response state");
`endif

endmodule

`default_nettype wire

// ===== verif/ntg_texel_checker.sv =====
// ----------------------------------------------------------------------------
// ntg_texel_checker
// Watches the request, response and seed channels of the noise texture
// generator. Keeps its own copy of the texel store and the generator
// registers, predicts one response per accepted request and compares each
// accepted response, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module ntg_texel_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   input  wire logic                               req_ready,
   input  wire logic                               req_kind,
   input  wire logic [ntg_pkg::AddrWidth-1:0]      req_read_address,
   input  wire logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   input  wire logic [ntg_pkg::TexelWidth-1:0]     rsp_data,
   input  wire logic [ntg_pkg::AddrWidth-1:0]      rsp_address,
   input  wire logic                               rsp_done_res,
   input  wire logic                               csr_valid,
   input  wire logic                               csr_ready,
   input  wire logic [ntg_pkg::TexelWidth-1:0]     csr_seed_byte,
   output int unsigned                             outstanding,
   output int unsigned                             fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import ntg_pkg::*;

   localparam logic [StepWidth-1:0] STEPS_TOTAL = {1'b1, {AddrWidth{1'b0}}};
   localparam int unsigned          REPORT_LIMIT = 10;
   localparam int unsigned          STORE_DEPTH  = 1 << AddrWidth;

   typedef struct packed {
      logic [TexelWidth-1:0] data;
      logic [AddrWidth-1:0]  address;
      logic                  done;
   } texel_rsp_type;

   logic [TexelWidth-1:0] texels [0:STORE_DEPTH-1];
   logic [TexelWidth-1:0] noise_acc;
   logic [TexelWidth-1:0] rot_reg;
   logic [TexelWidth-1:0] seed;
   logic                  carry;
   logic [StepWidth-1:0]  steps_done;
   texel_rsp_type         texel_rsp_q [$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   // One generation step or one texel read, applied to the local state.
   function automatic texel_rsp_type predict_texel(input logic kind,
                                                   input logic [AddrWidth-1:0] rd_addr);
      texel_rsp_type          r;
      logic [AddrWidth-1:0]   a;
      logic [AddrWidth-1:0]   ahead;
      logic [TexelWidth-1:0]  shifted;
      logic [TexelWidth:0]    sum;
      logic                   msb;
      int                     k;
      if (kind == KIND_READ) begin
         r.data    = texels[rd_addr];
         r.address = rd_addr;
         r.done    = (steps_done == STEPS_TOTAL);
         return r;
      end
      if (steps_done == STEPS_TOTAL) begin
         r.data    = '0;
         r.address = '0;
         r.done    = 1'b1;
         return r;
      end
      a = (steps_done == '0) ? '0 : AddrWidth'(STEPS_TOTAL - steps_done);
      if (steps_done == '0)
         rot_reg = seed;
      // 9-bit rotate of {carry, rot_reg}
      for (k = 0; k < int'(a[4:0]); k++) begin
         msb     = rot_reg[TexelWidth-1];
         rot_reg = {rot_reg[TexelWidth-2:0], carry};
         carry   = msb;
      end
      shifted   = {{3{rot_reg[TexelWidth-1]}}, rot_reg[TexelWidth-1:3]};
      sum       = {1'b0, noise_acc} + {1'b0, shifted} + rot_reg[2];
      carry     = sum[TexelWidth];
      noise_acc = sum[TexelWidth-1:0];
      ahead     = a + LOOKAHEAD;
      sum       = {1'b0, noise_acc} + {1'b0, texels[ahead]} + carry;
      noise_acc = sum[TexelWidth-1:0];
      carry     = noise_acc[0];
      noise_acc = noise_acc >> 1;
      texels[a]               = noise_acc;
      texels[a ^ MIRROR_MASK] = noise_acc;
      steps_done = steps_done + 1'b1;
      r.data    = noise_acc;
      r.address = a;
      r.done    = (steps_done == STEPS_TOTAL);
      return r;
   endfunction

   task automatic flag_field(input string field, input int unsigned want,
                             input int unsigned got);
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
         $display("[%0t] rsp_%s mismatch: expected %0h, got %0h", $time, field, want, got);
   endtask

   always @(posedge clock) begin
      texel_rsp_type want;
      int            i;
      if (reset) begin
         for (i = 0; i < STORE_DEPTH; i++)
            texels[i] = '0;
         noise_acc  = '0;
         rot_reg    = SEED_RESET;
         seed       = SEED_RESET;
         carry      = 1'b0;
         steps_done = '0;
         texel_rsp_q.delete();
      end else begin
         if (csr_valid && csr_ready)
            seed = csr_seed_byte;
         // response first: a request taken on this edge cannot be answered on it
         if (rsp_valid && rsp_ready) begin
            if (texel_rsp_q.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("[%0t] response with no request pending: data %0h address %0h done %0b",
                           $time, rsp_data, rsp_address, rsp_done_res);
            end else begin
               want = texel_rsp_q.pop_front();
               if (rsp_data !== want.data)
                  flag_field("data", want.data, rsp_data);
               if (rsp_address !== want.address)
                  flag_field("address", want.address, rsp_address);
               if (rsp_done_res !== want.done)
                  flag_field("done_res", want.done, rsp_done_res);
            end
         end
         if (req_valid && req_ready)
            texel_rsp_q.push_back(predict_texel(req_kind, req_read_address));
      end
      outstanding <= texel_rsp_q.size();
   end

endmodule

`default_nettype wire

// ===== verif/noise_texture_generator_tb.sv =====
// ----------------------------------------------------------------------------
// noise_texture_generator_tb
// Drives seed writes, generate and read requests into the noise texture
// generator with bursty requests and a stalling response side, runs the
// generator through all 65536 steps and past completion, and reports the
// verdict from the checker's mismatch and outstanding counts.
// ----------------------------------------------------------------------------
`default_nettype none

module noise_texture_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ntg_pkg::*;

   localparam int          RESET_CYCLES    = 10;
   localparam int          RANDOM_REQUESTS = 500;
   localparam int          TOTAL_STEPS     = 1 << AddrWidth;
   localparam int          DRAIN_CYCLES    = 64;
   localparam int unsigned CYCLE_LIMIT     = 10_000_000;

   logic                  clock;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic                  req_kind         = KIND_READ;
   logic [AddrWidth-1:0]  req_read_address = '0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   logic [TexelWidth-1:0] rsp_data;
   logic [AddrWidth-1:0]  rsp_address;
   logic                  rsp_done_res;
   logic                  csr_valid        = 1'b0;
   logic                  csr_ready;
   logic [TexelWidth-1:0] csr_seed_byte    = '0;

   int unsigned           outstanding;
   int unsigned           fail_count;
   int unsigned           cycle_count      = 0;
   int                    gen_issued       = 0;
   int                    burst_left       = 0;
   bit                    sender_gaps      = 1'b1;
   logic                  stall_on         = 1'b1;
   int                    stall_left       = 0;

   noise_texture_generator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_read_address (req_read_address),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .rsp_address      (rsp_address),
      .rsp_done_res     (rsp_done_res),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_seed_byte    (csr_seed_byte)
   );

   ntg_texel_checker texel_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_read_address (req_read_address),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .rsp_address      (rsp_address),
      .rsp_done_res     (rsp_done_res),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_seed_byte    (csr_seed_byte),
      .outstanding      (outstanding),
      .fail_count       (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("noise_texture_generator_tb: FAIL");
         $finish;
      end
   end

   // response side: random stalls while enabled, otherwise always ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (!stall_on) begin
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 7);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // valid is left high after an accept; within this task only a gap lowers it
   task automatic issue(input logic kind, input logic [AddrWidth-1:0] addr);
      int gap;
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_read_address <= addr;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      if (kind == KIND_GEN)
         gen_issued++;
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap        = sender_gaps ? $urandom_range(0, 6) : 0;
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   task automatic write_seed(input logic [TexelWidth-1:0] value, input bit last);
      csr_valid     <= 1'b1;
      csr_seed_byte <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      if (last)
         csr_valid <= 1'b0;
   endtask

   // mostly addresses around the latest step, so reads see fresh texels
   function automatic logic [AddrWidth-1:0] pick_read_address();
      int                   steps;
      logic [AddrWidth-1:0] last_a;
      steps  = (gen_issued > TOTAL_STEPS) ? TOTAL_STEPS : gen_issued;
      last_a = (steps <= 1) ? '0 : AddrWidth'(TOTAL_STEPS + 1 - steps);
      case ($urandom_range(0, 4))
         0: return AddrWidth'($urandom);
         1: return last_a;
         2: return last_a ^ MIRROR_MASK;
         3: return last_a + LOOKAHEAD;
         default: return $urandom_range(0, 1) ? '1 : '0;
      endcase
   endfunction

   initial begin
      logic [TexelWidth-1:0] run_seed;
      logic                  kind;
      int                    n;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // seed writes before the first step: only the last one counts
      case ($urandom_range(0, 2))
         0: run_seed = '0;
         1: run_seed = '1;
         default: run_seed = TexelWidth'($urandom);
      endcase
      write_seed('1, 1'b0);
      write_seed('0, 1'b0);
      write_seed(run_seed, 1'b1);

      // directed: empty store, first steps, mirrors, lookahead, both kinds
      issue(KIND_READ, '0);
      issue(KIND_READ, '1);
      issue(KIND_READ, 16'h8000);
      issue(KIND_GEN, '1);
      issue(KIND_READ, '0);
      issue(KIND_READ, MIRROR_MASK);
      issue(KIND_GEN, '0);
      repeat (5) issue(KIND_GEN, 16'h5555);
      issue(KIND_READ, '1);
      issue(KIND_READ, 16'h00FF);
      issue(KIND_READ, 16'h0080);
      issue(KIND_READ, 16'hFFFE);
      issue(KIND_READ, 16'h00FE);
      issue(KIND_READ, 16'h7FFF);
      issue(KIND_READ, 16'hAAAA);

      // seed writes once generation is running must not disturb it
      wait_idle();
      write_seed('0, 1'b0);
      write_seed('1, 1'b1);
      issue(KIND_GEN, 16'hAAAA);
      issue(KIND_GEN, '0);
      issue(KIND_READ, pick_read_address());

      // random mix with bursty sender and stalling receiver
      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 50 == 0) begin
            sender_gaps = ($urandom_range(0, 3) != 0);
            stall_on   <= ($urandom_range(0, 3) != 0);
         end
         if (n == RANDOM_REQUESTS / 2) begin
            wait_idle();
            write_seed(TexelWidth'($urandom), 1'b1);
         end
         kind = ($urandom_range(0, 9) < 6) ? KIND_GEN : KIND_READ;
         issue(kind, (kind == KIND_GEN) ? AddrWidth'($urandom) : pick_read_address());
      end

      // run the generator to completion at full rate, with a few reads
      sender_gaps = 1'b0;
      stall_on   <= 1'b0;
      while (gen_issued < TOTAL_STEPS) begin
         if ($urandom_range(0, 511) == 0)
            issue(KIND_READ, pick_read_address());
         else
            issue(KIND_GEN, AddrWidth'($urandom));
      end

      // after completion: generates report done and change nothing
      wait_idle();
      sender_gaps = 1'b1;
      stall_on   <= 1'b1;
      for (n = 0; n < 20; n++) begin
         kind = $urandom_range(0, 1) ? KIND_GEN : KIND_READ;
         issue(kind, (kind == KIND_GEN) ? AddrWidth'($urandom) : pick_read_address());
      end
      wait_idle();
      write_seed(TexelWidth'($urandom), 1'b1);
      issue(KIND_GEN, '1);
      issue(KIND_READ, AddrWidth'($urandom));
      issue(KIND_GEN, '0);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("noise_texture_generator_tb: PASS");
      else
         $display("noise_texture_generator_tb: FAIL");
      $finish;
   end

endmodule

`default_nettype wire

// ===== noise_texture_generator.f =====
hdl/ntg_pkg.sv
hdl/noise_texture_generator.sv
verif/ntg_texel_checker.sv
verif/noise_texture_generator_tb.sv
